// ===== hdl/sm83d_pkg.sv =====
// Package for the SM83 instruction stream decoder: mnemonic codes, decode
// phases, the record types passed between front end, queues and back end,
// and the first-byte decode table. No dependencies.
`timescale 1ns / 1ps

package sm83d_pkg;

  typedef enum logic [5:0] {
    MN_INVALID, MN_NOP, MN_LD_RR_NN, MN_LD_IND_A, MN_INC_RR, MN_INC_R,
    MN_DEC_R, MN_LD_R_N, MN_RLCA, MN_LD_NN_SP, MN_ADD_HL_RR, MN_LD_A_IND,
    MN_DEC_RR, MN_RRCA, MN_STOP, MN_RLA, MN_JR, MN_JR_CC, MN_RRA, MN_DAA,
    MN_CPL, MN_SCF, MN_CCF, MN_HALT, MN_LD_R_R, MN_ALU_R, MN_RET_CC, MN_POP,
    MN_JP_CC, MN_JP, MN_CALL_CC, MN_PUSH, MN_ALU_N, MN_RST, MN_RET, MN_CALL,
    MN_RETI, MN_LDH_N_A, MN_LD_C_A, MN_ADD_SP_E, MN_JP_HL, MN_LD_NN_A,
    MN_LDH_A_N, MN_DI, MN_LD_HL_SPE, MN_LD_SP_HL, MN_LD_A_NN, MN_EI,
    MN_CB_SHIFT, MN_BIT, MN_RES, MN_SET
  } mnemonic_t;

  typedef enum logic [1:0] {
    PH_OPCODE,
    PH_ARG1,
    PH_ARG2
  } phase_t;

  localparam logic [7:0] RST_VEC_MASK = 8'h38;

  // decode of the first opcode byte; extra is the number of operand bytes
  typedef struct packed {
    mnemonic_t   mn;
    logic [2:0]  a;
    logic [2:0]  b;
    logic [1:0]  extra;
    logic        bad;
  } form_t;

  // assembled instruction, front end to back end
  typedef struct packed {
    logic [22:0] instr_offset;
    logic [8:0]  rom_bank;
    logic [14:0] bank_address;
    logic [14:0] next_address;
    logic [1:0]  len;
    logic [7:0]  op;
    logic [15:0] imm;
  } rec_t;

  // finished result word
  typedef struct packed {
    logic [22:0] instr_offset;
    logic [8:0]  rom_bank;
    logic [14:0] bank_address;
    logic [1:0]  instr_length;
    logic [7:0]  opcode_byte;
    mnemonic_t   mnemonic;
    logic [2:0]  operand_a;
    logic [2:0]  operand_b;
    logic [15:0] immediate;
    logic [15:0] jump_target;
    logic        invalid;
  } res_t;

  function automatic form_t mk(input mnemonic_t mn, input logic [2:0] a,
                               input logic [2:0] b, input logic [1:0] extra);
    form_t f;
    f.mn    = mn;
    f.a     = a;
    f.b     = b;
    f.extra = extra;
    f.bad   = 1'b0;
    return f;
  endfunction

  function automatic form_t decode_first(input logic [7:0] op);
    logic [2:0] r8;
    logic [2:0] p;
    logic [2:0] cc;
    form_t      f;
    r8 = op[5:3];
    p  = {1'b0, op[5:4]};
    cc = {1'b0, op[4:3]};
    f  = mk(MN_INVALID, 3'd0, 3'd0, 2'd0);
    f.bad = 1'b1;
    unique case (op[7:6])
      2'b01: begin
        if (op == 8'h76) return mk(MN_HALT, 3'd0, 3'd0, 2'd0);
        return mk(MN_LD_R_R, r8, op[2:0], 2'd0);
      end
      2'b10: return mk(MN_ALU_R, r8, op[2:0], 2'd0);
      2'b00: begin
        unique case (op[3:0])
          4'h1: return mk(MN_LD_RR_NN, p, 3'd0, 2'd2);
          4'h2: return mk(MN_LD_IND_A, p, 3'd0, 2'd0);
          4'h3: return mk(MN_INC_RR, p, 3'd0, 2'd0);
          4'h9: return mk(MN_ADD_HL_RR, p, 3'd0, 2'd0);
          4'ha: return mk(MN_LD_A_IND, p, 3'd0, 2'd0);
          4'hb: return mk(MN_DEC_RR, p, 3'd0, 2'd0);
          default: ;
        endcase
        unique case (op[2:0])
          3'd4: return mk(MN_INC_R, r8, 3'd0, 2'd0);
          3'd5: return mk(MN_DEC_R, r8, 3'd0, 2'd0);
          3'd6: return mk(MN_LD_R_N, r8, 3'd0, 2'd1);
          default: ;
        endcase
        unique case (op)
          8'h00: return mk(MN_NOP, 3'd0, 3'd0, 2'd0);
          8'h07: return mk(MN_RLCA, 3'd0, 3'd0, 2'd0);
          8'h08: return mk(MN_LD_NN_SP, 3'd0, 3'd0, 2'd2);
          8'h0f: return mk(MN_RRCA, 3'd0, 3'd0, 2'd0);
          8'h10: return mk(MN_STOP, 3'd0, 3'd0, 2'd0);
          8'h17: return mk(MN_RLA, 3'd0, 3'd0, 2'd0);
          8'h18: return mk(MN_JR, 3'd0, 3'd0, 2'd1);
          8'h1f: return mk(MN_RRA, 3'd0, 3'd0, 2'd0);
          8'h27: return mk(MN_DAA, 3'd0, 3'd0, 2'd0);
          8'h2f: return mk(MN_CPL, 3'd0, 3'd0, 2'd0);
          8'h37: return mk(MN_SCF, 3'd0, 3'd0, 2'd0);
          8'h3f: return mk(MN_CCF, 3'd0, 3'd0, 2'd0);
          default: return mk(MN_JR_CC, cc, 3'd0, 2'd1);
        endcase
      end
      default: begin
        if (op[2:0] == 3'd6) return mk(MN_ALU_N, r8, 3'd0, 2'd1);
        if (op[2:0] == 3'd7) return mk(MN_RST, r8, 3'd0, 2'd0);
        if (op[5] == 1'b0) begin
          unique case (op)
            8'hc0, 8'hc8, 8'hd0, 8'hd8: return mk(MN_RET_CC, cc, 3'd0, 2'd0);
            8'hc2, 8'hca, 8'hd2, 8'hda: return mk(MN_JP_CC, cc, 3'd0, 2'd2);
            8'hc4, 8'hcc, 8'hd4, 8'hdc: return mk(MN_CALL_CC, cc, 3'd0, 2'd2);
            default: ;
          endcase
        end
        if (op[3:0] == 4'h1) return mk(MN_POP, p, 3'd0, 2'd0);
        if (op[3:0] == 4'h5) return mk(MN_PUSH, p, 3'd0, 2'd0);
        unique case (op)
          8'hc3: return mk(MN_JP, 3'd0, 3'd0, 2'd2);
          8'hc9: return mk(MN_RET, 3'd0, 3'd0, 2'd0);
          8'hcb: return mk(MN_CB_SHIFT, 3'd0, 3'd0, 2'd1);
          8'hcd: return mk(MN_CALL, 3'd0, 3'd0, 2'd2);
          8'hd9: return mk(MN_RETI, 3'd0, 3'd0, 2'd0);
          8'he0: return mk(MN_LDH_N_A, 3'd0, 3'd0, 2'd1);
          8'he2: return mk(MN_LD_C_A, 3'd0, 3'd0, 2'd0);
          8'he8: return mk(MN_ADD_SP_E, 3'd0, 3'd0, 2'd1);
          8'he9: return mk(MN_JP_HL, 3'd0, 3'd0, 2'd0);
          8'hea: return mk(MN_LD_NN_A, 3'd0, 3'd0, 2'd2);
          8'hf0: return mk(MN_LDH_A_N, 3'd0, 3'd0, 2'd1);
          8'hf3: return mk(MN_DI, 3'd0, 3'd0, 2'd0);
          8'hf8: return mk(MN_LD_HL_SPE, 3'd0, 3'd0, 2'd1);
          8'hf9: return mk(MN_LD_SP_HL, 3'd0, 3'd0, 2'd0);
          8'hfa: return mk(MN_LD_A_NN, 3'd0, 3'd0, 2'd2);
          8'hfb: return mk(MN_EI, 3'd0, 3'd0, 2'd0);
          default: ;
        endcase
      end
    endcase
    return f;
  endfunction

endpackage

// ===== hdl/sm83d_fifo.sv =====
// Two-entry queue of fixed-width words with simultaneous push and pop.
// Used between front and back end and as the result stage. No dependencies.
`timescale 1ns / 1ps

module sm83d_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             full,
  output logic             empty
);

  logic [WIDTH-1:0] mem [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop) rd_ptr <= !rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== hdl/sm83d_front.sv =====
// Front end: assembles code bytes into whole instructions and tracks offsets.
// Depends on sm83d_pkg for the phase type, the record type and decode_first.
`timescale 1ns / 1ps

module sm83d_front
  import sm83d_pkg::*;
#(
  parameter int OFFSET_BITS = 23
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [22:0] cfg_offset,
  input  logic        byte_valid,
  input  logic [7:0]  code_byte,
  output logic        rec_push,
  output rec_t        rec
);

  phase_t                 phase;
  phase_t                 phase_next;
  logic [7:0]             held_opcode;
  logic [7:0]             held_low_byte;
  logic                   held_long;
  logic [OFFSET_BITS-1:0] byte_position;
  logic [OFFSET_BITS-1:0] instr_start;

  form_t                  first_form;
  logic [1:0]             first_extra;
  logic                   emit;
  logic [1:0]             len;
  logic [15:0]            imm;
  logic [7:0]             op_sel;
  logic [OFFSET_BITS-1:0] start_sel;
  logic [OFFSET_BITS-1:0] next_pos;
  logic [31:0]            start_ext;

  assign first_form  = decode_first(code_byte);
  assign first_extra = first_form.extra;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_OPCODE;
      byte_position <= '0;
      instr_start   <= '0;
    end else begin
      phase <= phase_next;
      if (cfg_we) begin
        byte_position <= OFFSET_BITS'(cfg_offset);
      end else if (byte_valid) begin
        byte_position <= byte_position + OFFSET_BITS'(1);
        if (phase != PH_ARG1 && phase != PH_ARG2) instr_start <= byte_position;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !cfg_we) begin
      if (phase == PH_ARG1) begin
        held_low_byte <= code_byte;
      end else if (phase != PH_ARG2) begin
        held_opcode <= code_byte;
        held_long   <= (first_extra == 2'd2);
      end
    end
  end

  always_comb begin
    phase_next = phase;
    emit       = 1'b0;
    len        = 2'd1;
    imm        = 16'h0000;
    start_sel  = instr_start;
    op_sel     = held_opcode;
    unique case (phase)
      PH_ARG1: begin
        if (held_long) begin
          phase_next = PH_ARG2;
        end else begin
          emit       = 1'b1;
          len        = 2'd2;
          imm        = {8'h00, code_byte};
          phase_next = PH_OPCODE;
        end
      end
      PH_ARG2: begin
        emit       = 1'b1;
        len        = 2'd3;
        imm        = {code_byte, held_low_byte};
        phase_next = PH_OPCODE;
      end
      default: begin
        start_sel = byte_position;
        op_sel    = code_byte;
        if (first_extra == 2'd0) begin
          emit       = 1'b1;
          phase_next = PH_OPCODE;
        end else begin
          phase_next = PH_ARG1;
        end
      end
    endcase
    // hold the phase unless a byte arrives; a start offset write restarts
    if (!byte_valid) phase_next = phase;
    if (cfg_we) phase_next = PH_OPCODE;
  end

  assign next_pos  = start_sel + OFFSET_BITS'(2);
  assign start_ext = 32'(start_sel);

  assign rec.instr_offset = start_ext[22:0];
  assign rec.rom_bank     = start_ext[22:14];
  assign rec.bank_address = {|start_sel[OFFSET_BITS-1:14], start_sel[13:0]};
  assign rec.next_address = {|next_pos[OFFSET_BITS-1:14], next_pos[13:0]};
  assign rec.len          = len;
  assign rec.op           = op_sel;
  assign rec.imm          = imm;
  assign rec_push         = byte_valid && !cfg_we && emit;

endmodule

// ===== hdl/sm83d_back.sv =====
// Back end: expands an assembled instruction into the result word
// (mnemonic, selectors, rst vector, cb forms, relative jump target).
// Depends on sm83d_pkg.
`timescale 1ns / 1ps

module sm83d_back
  import sm83d_pkg::*;
(
  input  rec_t  rec,
  input  logic  rec_valid,
  input  logic  res_full,
  output logic  rec_pop,
  output logic  res_push,
  output res_t  res
);

  form_t       f;
  logic [15:0] rel;

  assign f   = decode_first(rec.op);
  assign rel = {{8{rec.imm[7]}}, rec.imm[7:0]};

  always_comb begin
    res.instr_offset = rec.instr_offset;
    res.rom_bank     = rec.rom_bank;
    res.bank_address = rec.bank_address;
    res.instr_length = rec.len;
    res.opcode_byte  = rec.op;
    res.mnemonic     = f.mn;
    res.operand_a    = f.a;
    res.operand_b    = f.b;
    res.immediate    = rec.imm;
    res.jump_target  = 16'h0000;
    res.invalid      = f.bad;
    unique case (f.mn) inside
      MN_JR, MN_JR_CC: begin
        res.jump_target = {1'b0, rec.next_address} + rel;
      end
      MN_RST: begin
        res.immediate = {8'h00, rec.op & RST_VEC_MASK};
      end
      MN_CB_SHIFT: begin
        // second byte picks rotate/shift, bit, res or set
        res.mnemonic  = mnemonic_t'(6'(MN_CB_SHIFT) + {4'b0000, rec.imm[7:6]});
        res.operand_a = rec.imm[5:3];
        res.operand_b = rec.imm[2:0];
      end
      default: ;
    endcase
  end

  assign rec_pop  = rec_valid && !res_full;
  assign res_push = rec_pop;

endmodule

// ===== hdl/sm83_instruction_stream_decoder_top.sv =====
// SM83 instruction stream decoder, top level.
// Depends on sm83d_pkg, sm83d_front, sm83d_fifo and sm83d_back.
//
// Usage:
//   Input queue side: drive code_byte with push; a byte is taken on a clock
//   edge with push high and full low. One byte per cycle is sustained while full is low.
//   Result queue side: while empty is low the oldest finished instruction
//   is on the result ports; pop it with pop high. Results leave in order.
//   Configuration: start_offset is written on cfg_valid (cfg_ready is always
//   high); the user is to write it only while the block is idle, which the
//   block does not enforce. It sets the offset of the next byte and drops a
//   partly assembled instruction.
// Timing: the front end writes a finished instruction into a two-entry queue
//   at the edge that takes its last byte; the back end moves it from there into
//   a two-entry result queue, unless that queue is full, and it is then on the ports.
//   Throughput is one byte per cycle while full is low; there is no iteration.
// Reset (rst, synchronous): both queues empty, phase back to opcode, offset 0.
// Stall: when pop is held low the result queue fills, the back end holds,
//   the middle queue fills and full rises; no byte or result is dropped.
`timescale 1ns / 1ps

module sm83_instruction_stream_decoder_top
  import sm83d_pkg::*;
#(
  parameter int OFFSET_BITS = 23
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [22:0] start_offset,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  code_byte,
  output logic        empty,
  input  logic        pop,
  output logic [22:0] instr_offset,
  output logic [8:0]  rom_bank,
  output logic [14:0] bank_address,
  output logic [1:0]  instr_length,
  output logic [7:0]  opcode_byte,
  output logic [5:0]  mnemonic,
  output logic [2:0]  operand_a,
  output logic [2:0]  operand_b,
  output logic [15:0] immediate,
  output logic [15:0] jump_target,
  output logic        invalid
);

  rec_t front_rec;
  rec_t mid_rec;
  logic front_push;
  logic mid_full;
  logic mid_empty;
  logic mid_pop;
  logic res_push;
  logic res_full;
  res_t back_res;
  res_t out_res;

  assign cfg_ready = 1'b1;
  assign full      = mid_full;

  sm83d_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_offset(start_offset),
    .byte_valid(push && !mid_full),
    .code_byte (code_byte),
    .rec_push  (front_push),
    .rec       (front_rec)
  );

  sm83d_fifo #(
    .WIDTH($bits(rec_t))
  ) u_mid_q (
    .clk  (clk),
    .rst  (rst),
    .push (front_push),
    .din  (front_rec),
    .pop  (mid_pop),
    .dout (mid_rec),
    .full (mid_full),
    .empty(mid_empty)
  );

  sm83d_back u_back (
    .rec      (mid_rec),
    .rec_valid(!mid_empty),
    .res_full (res_full),
    .rec_pop  (mid_pop),
    .res_push (res_push),
    .res      (back_res)
  );

  sm83d_fifo #(
    .WIDTH($bits(res_t))
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .din  (back_res),
    .pop  (pop),
    .dout (out_res),
    .full (res_full),
    .empty(empty)
  );

  assign instr_offset = out_res.instr_offset;
  assign rom_bank     = out_res.rom_bank;
  assign bank_address = out_res.bank_address;
  assign instr_length = out_res.instr_length;
  assign opcode_byte  = out_res.opcode_byte;
  assign mnemonic     = out_res.mnemonic;
  assign operand_a    = out_res.operand_a;
  assign operand_b    = out_res.operand_b;
  assign immediate    = out_res.immediate;
  assign jump_target  = out_res.jump_target;
  assign invalid      = out_res.invalid;

endmodule

// ===== hdl/sm83d_checker.sv =====
// Port-level checks for the SM83 instruction stream decoder, bound to the
// top level. Depends on sm83d_pkg for mnemonic codes.
`timescale 1ns / 1ps

module sm83d_checker
  import sm83d_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        empty,
  input logic        pop,
  input logic [22:0] instr_offset,
  input logic [1:0]  instr_length,
  input logic [5:0]  mnemonic,
  input logic [15:0] jump_target,
  input logic        invalid
);

  // result queue comes out of reset drained
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  // a stalled result word holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(instr_offset)))
    else $error("stalled result word changed");

  // an undecoded opcode is a one-byte result with the invalid code
  a_invalid_form: assert property (@(posedge clk) disable iff (rst)
    (!empty && invalid) |-> (mnemonic == 6'(MN_INVALID) && instr_length == 2'd1))
    else $error("invalid opcode with wrong form");

  // only relative jumps carry a target
  a_target_jr_only: assert property (@(posedge clk) disable iff (rst)
    (!empty && mnemonic != 6'(MN_JR) && mnemonic != 6'(MN_JR_CC))
      |-> (jump_target == 16'h0000))
    else $error("jump target on non-jump instruction");

endmodule

bind sm83_instruction_stream_decoder_top sm83d_checker u_sm83d_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .instr_offset(instr_offset),
  .instr_length(instr_length),
  .mnemonic    (mnemonic),
  .jump_target (jump_target),
  .invalid     (invalid)
);
